// ===== rtl/mrpc_pkg.sv =====
`default_nettype none
package mrpc_pkg;

    localparam int NumLanes = 7;
    localparam int QuoBits  = 8;

    // One division in flight: partial remainder, unconsumed low numerator bits,
    // divisor and the quotient bits found so far.
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] num;
        logic [7:0] den;
        logic [7:0] quo;
    } t_lane;

    typedef t_lane [NumLanes-1:0] t_lanes;

    localparam logic [7:0] ProbMax  = 8'd255;
    localparam logic [7:0] ProbHalf = 8'd128;
    localparam logic [7:0] ProbMin  = 8'd1;

    // floor(x / 255) for any 16-bit x below 65280 (quotient fits in eight bits), as ((x + 1) * 257) >> 16.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] x1;
        logic [24:0] s;
        x1 = {1'b0, x} + 17'd1;
        s  = {x1, 8'b0} + {8'b0, x1};
        return s[23:16];
    endfunction

    // Starts the long division of c * 255 by den. Since c <= den the
    // quotient fits in eight bits and the high byte is already below den.
    function automatic t_lane lane_init(input logic [7:0] c, input logic [7:0] den);
        logic [15:0] n;
        t_lane       l;
        n     = {c, 8'b0} - {8'b0, c};
        l.rem = n[15:8];
        l.num = n[7:0];
        l.den = den;
        l.quo = '0;
        return l;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mrpc_front.sv =====
`default_nettype none
module mrpc_front
    import mrpc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_ip,
    input  wire logic [7:0] i_lp,
    input  wire logic [7:0] i_gp,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_lanes          o_lanes
);

    logic        r_v1, r_v2, r_v3, r_v4;
    logic        rdy1, rdy2, rdy3, rdy4;
    logic [7:0]  r_ip1, r_gp1, r_ip2, r_gp2, r_last2, r_ga2, r_ip3, r_last3, r_ga3;
    logic [15:0] r_prod1, r_prod3;
    t_lanes      r_lanes;
    t_lanes      n_lanes;
    logic [7:0]  last2, ga2, gold4, alt4;
    logic [8:0]  inter2;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v4;
    assign o_lanes = r_lanes;

    assign inter2 = {1'b0, ProbMax} - {1'b0, r_ip1};
    assign last2  = div255(r_prod1);
    assign ga2    = inter2[7:0] - last2;
    assign gold4  = div255(r_prod3);
    assign alt4   = r_ga3 - gold4;

    always_comb begin
        logic [8:0] t0, t1, t2, t3, t4;
        t0 = {1'b0, r_ip3} + {1'b0, r_ga3};
        t1 = {1'b0, r_ip3} + {1'b0, r_last3} + {1'b0, alt4};
        t2 = {1'b0, r_last3} + {1'b0, alt4};
        t3 = {1'b0, r_ip3} + {1'b0, r_last3} + {1'b0, gold4};
        t4 = {1'b0, r_last3} + {1'b0, gold4};
        n_lanes[0] = lane_init(r_last3, r_ga3 + r_last3);
        n_lanes[1] = lane_init(gold4, r_ga3);
        n_lanes[2] = lane_init(r_ip3, t0[7:0]);
        n_lanes[3] = lane_init(r_ip3, t1[7:0]);
        n_lanes[4] = lane_init(r_last3, t2[7:0]);
        n_lanes[5] = lane_init(r_ip3, t3[7:0]);
        n_lanes[6] = lane_init(r_last3, t4[7:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_ip1   <= i_ip;
            r_gp1   <= i_gp;
            r_prod1 <= {8'd0, ProbMax - i_ip} * {8'd0, i_lp};
        end
        if (rdy2 && r_v1) begin
            r_ip2   <= r_ip1;
            r_gp2   <= r_gp1;
            r_last2 <= last2;
            r_ga2   <= ga2;
        end
        if (rdy3 && r_v2) begin
            r_ip3   <= r_ip2;
            r_last3 <= r_last2;
            r_ga3   <= r_ga2;
            r_prod3 <= {8'd0, r_ga2} * {8'd0, r_gp2};
        end
        if (rdy4 && r_v3) begin
            r_lanes <= n_lanes;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mrpc_div_cell.sv =====
`default_nettype none
module mrpc_div_cell
    import mrpc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_lanes i_lanes,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_lanes      o_lanes
);

    logic   r_v;
    t_lanes r_lanes;
    t_lanes n_lanes;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_lanes = r_lanes;

    // One restoring step per lane: bring down a numerator bit, subtract if it fits.
    always_comb begin
        logic [8:0] t;
        logic [8:0] d;
        for (int k = 0; k < NumLanes; k++) begin
            t = {i_lanes[k].rem, i_lanes[k].num[7]};
            d = {1'b0, i_lanes[k].den};
            n_lanes[k].den = i_lanes[k].den;
            n_lanes[k].num = {i_lanes[k].num[6:0], 1'b0};
            if (t >= d) begin
                t = t - d;
                n_lanes[k].quo = {i_lanes[k].quo[6:0], 1'b1};
            end else begin
                n_lanes[k].quo = {i_lanes[k].quo[6:0], 1'b0};
            end
            n_lanes[k].rem = t[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lanes <= n_lanes;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/modified_ref_prob_calculator.sv =====
`default_nettype none
// Throughput: one request per cycle unless the master side stalls; four front stages derive
// the counts, eight divider cells each resolve one quotient bit, one output register follows.
// Every stage stalls only when it is full and the stage after it cannot take its data.
// Reset (i_rst_n low, synchronous) clears every valid bit; no data is kept between requests.
module modified_ref_prob_calculator
    import mrpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // intra_prob[7:0], last_prob[15:8], golden_prob[23:16]
    input  wire logic [23:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // intra_p0, intra_p1, intra_p2, last_p0, last_p1, last_p2, golden_p0,
    // golden_p1, golden_p2, altref_p0, altref_p1, altref_p2, 8 bits each from bit 0 up
    output logic [95:0]      m_axis_tdata
);

    // Valid, ready and lane data between the links of the chain; link 0 is the front end.
    logic   v  [QuoBits+1];
    logic   rd [QuoBits+1];
    t_lanes ln [QuoBits+1];

    logic        r_ov;
    logic [95:0] r_od;
    logic [95:0] n_od;
    logic        out_rdy;
    logic [7:0]  p [NumLanes];

    mrpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_ip    (s_axis_tdata[7:0]),
        .i_lp    (s_axis_tdata[15:8]),
        .i_gp    (s_axis_tdata[23:16]),
        .o_valid (v[0]),
        .i_ready (rd[0]),
        .o_lanes (ln[0])
    );

    // Each cell produces the next quotient bit, most significant first.
    for (genvar g = 0; g < QuoBits; g++) begin : g_cell
        mrpc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[g]),
            .o_ready (rd[g]),
            .i_lanes (ln[g]),
            .o_valid (v[g+1]),
            .i_ready (rd[g+1]),
            .o_lanes (ln[g+1])
        );
    end

    assign out_rdy       = !r_ov || m_axis_tready;
    assign rd[QuoBits]   = out_rdy;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

    // An empty remaining total gives one half; a zero quotient is raised to the minimum.
    always_comb begin
        for (int k = 0; k < NumLanes; k++) begin
            if (ln[QuoBits][k].den == 8'd0) begin
                p[k] = ProbHalf;
            end else if (ln[QuoBits][k].quo == 8'd0) begin
                p[k] = ProbMin;
            end else begin
                p[k] = ln[QuoBits][k].quo;
            end
        end
        // The implicit branch of each row is forced to zero.
        n_od = {8'd0, p[6], p[5],
                8'd0, p[4], p[3],
                p[1], 8'd0, p[2],
                p[1], p[0], 8'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_rdy) begin
            r_ov <= v[QuoBits];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && v[QuoBits]) begin
            r_od <= n_od;
        end
    end

    // The input side can only be held off while the output is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // The computed nodes intra_p1, intra_p2, last_p0 and altref_p1 are never zero.
    a_node_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:8] != 8'd0 && m_axis_tdata[23:16] != 8'd0
                           && m_axis_tdata[31:24] != 8'd0 && m_axis_tdata[87:80] != 8'd0))
        else $error("computed probability is zero");

    // No result may appear in the cycle right after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule
`default_nettype wire

// ===== bench/tb_modified_ref_prob_calculator.sv =====
`default_nettype none
module tb_modified_ref_prob_calculator;

    // Number of fields in one result, matching the packing of m_axis_tdata.
    localparam int NumProbs = 12;
    localparam int CycleLimit = 200000;
    localparam int Latency = 13;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // intra_prob[7:0], last_prob[15:8], golden_prob[23:16]
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // intra_p0 .. altref_p2, 8 bits each from bit 0 up
    logic [95:0] m_axis_tdata;

    typedef struct packed {
        logic [7:0] golden_prob;
        logic [7:0] last_prob;
        logic [7:0] intra_prob;
    } t_request;

    t_request    pending_requests[$];
    logic [95:0] expected_probs[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          stimulus_done = 1'b0;
    bit          drain_hold = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_phase = 0;

    modified_ref_prob_calculator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // One binary tree node: floor(c*255/total), a zero raised to one,
    // and one half when nothing remains below the node.
    function automatic logic [7:0] node_prob(input int unsigned c, input int unsigned total);
        int unsigned q;
        if (total == 0) begin
            return 8'd128;
        end
        q = (c * 255) / total;
        if (q[7:0] == 8'd0) begin
            return 8'd1;
        end
        return q[7:0];
    endfunction

    // Builds the twelve probabilities for one request. Each row drops one
    // reference kind, and each row forces its implicit node to zero.
    function automatic logic [95:0] ref_frame_probs(input t_request r);
        int unsigned cnt[4];
        int unsigned row[4];
        int unsigned inter, last_c, gold_alt, gold_c, alt_c, total;
        logic [7:0]  p[NumProbs];
        logic [95:0] packed_probs;
        inter = 255 - r.intra_prob;
        last_c = (inter * r.last_prob) / 255;
        gold_alt = inter - last_c;
        gold_c = (gold_alt * r.golden_prob) / 255;
        alt_c = gold_alt - gold_c;
        cnt[0] = r.intra_prob;
        cnt[1] = last_c;
        cnt[2] = gold_c;
        cnt[3] = alt_c;
        for (int k = 0; k < 4; k++) begin
            row = cnt;
            row[k] = 0;
            total = row[0] + row[1] + row[2] + row[3];
            p[3*k] = node_prob(row[0], total);
            total -= row[0];
            p[3*k+1] = node_prob(row[1], total);
            total -= row[1];
            p[3*k+2] = node_prob(row[2], total);
        end
        // Implicit branches: intra node 0, last node 1, golden and altref node 2.
        p[0] = 8'd0;
        p[4] = 8'd0;
        p[8] = 8'd0;
        p[11] = 8'd0;
        for (int k = 0; k < NumProbs; k++) begin
            packed_probs[8*k +: 8] = p[k];
        end
        return packed_probs;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH %s at cycle %0d", what, cycle_count);
        mismatch_count++;
    endtask

    // Driver: bursts of requests separated by random gaps. When drain_hold
    // is raised it stops until every expected result has arrived.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_probs.push_back(ref_frame_probs(s_axis_tdata));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_requests.size() == 0 || (drain_hold &&
                             (expected_probs.size() != 0 || s_axis_tvalid))) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_requests.pop_front();
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Monitor: compares each accepted result with the oldest expectation and
    // stalls the result side on a repeating pattern with random stretches.
    always @(posedge i_clk) begin
        logic [95:0] want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_probs.size() == 0) begin
                    report_mismatch("unexpected result");
                end else begin
                    want = expected_probs.pop_front();
                    for (int k = 0; k < NumProbs; k++) begin
                        if (m_axis_tdata[8*k +: 8] !== want[8*k +: 8]) begin
                            report_mismatch($sformatf("prob[%0d]: got %0d expected %0d", k,
                                                      m_axis_tdata[8*k +: 8],
                                                      want[8*k +: 8]));
                        end
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 64;
            if (stall_phase < 20) begin
                m_axis_tready <= 1'b1;
            end else if (stall_phase < 40) begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end else begin
                m_axis_tready <= ($urandom_range(0, 1) != 0);
            end
        end
    end

    initial begin
        t_request r;
        int       edges[4];
        edges = '{0, 1, 254, 255};
        // Directed part: field extremes, empty totals and tiny quotients.
        foreach (edges[a]) begin
            r = '{golden_prob: edges[a], last_prob: edges[3-a], intra_prob: edges[a]};
            pending_requests.push_back(r);
        end
        pending_requests.push_back('{8'd0, 8'd0, 8'd0});
        pending_requests.push_back('{8'd255, 8'd255, 8'd255});
        pending_requests.push_back('{8'd255, 8'd255, 8'd0});
        pending_requests.push_back('{8'd0, 8'd0, 8'd255});
        pending_requests.push_back('{8'd0, 8'd255, 8'd0});
        pending_requests.push_back('{8'd255, 8'd0, 8'd0});
        pending_requests.push_back('{8'd128, 8'd128, 8'd128});
        pending_requests.push_back('{8'd1, 8'd1, 8'd254});
        pending_requests.push_back('{8'd170, 8'd85, 8'd170});
        pending_requests.push_back('{8'd254, 8'd1, 8'd1});
        // Random part: mostly full range, some values pushed to the ends.
        for (int n = 0; n < 1000; n++) begin
            r.intra_prob = ($urandom_range(0, 4) == 0) ? edges[$urandom_range(0, 3)]
                                                       : $urandom_range(0, 255);
            r.last_prob = ($urandom_range(0, 4) == 0) ? edges[$urandom_range(0, 3)]
                                                      : $urandom_range(0, 255);
            r.golden_prob = $urandom_range(0, 255);
            pending_requests.push_back(r);
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Let part of the stream through, then hold until the pipe is empty.
        wait (pending_requests.size() < 600);
        @(posedge i_clk);
        drain_hold <= 1'b1;
        wait (expected_probs.size() == 0 && !s_axis_tvalid);
        repeat (5) @(posedge i_clk);
        drain_hold <= 1'b0;
        wait (pending_requests.size() == 0);
        @(posedge i_clk);
        wait (!s_axis_tvalid);
        stimulus_done = 1'b1;
    end

    initial begin
        wait (stimulus_done && expected_probs.size() == 0);
        repeat (Latency * 2) @(posedge i_clk);
        if (mismatch_count == 0 && expected_probs.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CycleLimit);
        $display("TIMEOUT at cycle %0d", cycle_count);
        $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/mrpc_pkg.sv
rtl/mrpc_front.sv
rtl/mrpc_div_cell.sv
rtl/modified_ref_prob_calculator.sv
bench/tb_modified_ref_prob_calculator.sv
